// File: rtl/core/uart_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the tick-driven 8N1 UART transceiver.
// Depends on nothing; used by uart_8n1_tick_transceiver_unit.
package uart_pkg;

  // Receive queue depth and the pointer width that follows from it.
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int BYTE_W      = 8;
  localparam int ACTION_W    = 2;
  localparam int FRAME_W     = 10;
  localparam int BITS_LEFT_W = 4;
  localparam int BIT_CNT_W   = 3;

  // Request codes carried on the action field.
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EDGE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEND = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd3;

  // Frame layout: start bit low in bit 0, data in bits 8:1, stop bit high in bit 9.
  localparam logic [FRAME_W-1:0]     STOP_MARK  = 10'h200;
  localparam logic [BITS_LEFT_W-1:0] FRAME_BITS = 4'd10;
  localparam logic [BIT_CNT_W-1:0]   LAST_DATA_BIT = 3'd7;

  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] pos);
    logic [PTR_W-1:0] res;
    if (pos == LAST_POS) begin
      res = '0;
    end else begin
      res = pos + 1'b1;
    end
    return res;
  endfunction

endpackage

// File: rtl/core/uart_8n1_tick_transceiver_unit.sv
`timescale 1ns / 1ps
// Top level of the tick-driven 8N1 UART transceiver with its receive ring queue.
// Depends on uart_pkg and instantiates uart_ram for the queue storage.
//
// Usage:
// Each request on the input channel (in_valid / in_ready) is one event: a bit
// tick, a falling edge on the receive line, a byte to send, or a read of the
// receive queue. Every request produces exactly one result on the output
// channel (out_valid / out_ready). The configuration channel (cfg_valid /
// cfg_ready, cfg_data) writes the receive enable bit; it is always ready and
// should only be used while no result is outstanding.
// The result of a request accepted at one edge is presented from the next
// cycle. Throughput is one request per cycle while the consumer takes each
// result; the single result register is refilled in the same cycle it is
// taken, and the queue RAM read data register supplies the result's byte.
// If the consumer stalls, the result register holds and in_ready drops until
// the result is taken; no state advances meanwhile.
// Reset (rst, synchronous, active high) idles the transmit line high, clears
// the transmitter, receiver and queue pointers, and sets the receive enable.
// Queue contents are not cleared; the pointers guarantee only written
// entries are read. An overflow overwrites the oldest data and makes the
// queue read as empty.
module uart_8n1_tick_transceiver_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [uart_pkg::ACTION_W-1:0] action,
  input  logic                          rx_level,
  input  logic [uart_pkg::BYTE_W-1:0]   tx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          tx_line,
  output logic                          tx_busy,
  output logic                          accepted,
  output logic [uart_pkg::BYTE_W-1:0]   read_byte,
  output logic                          read_valid,
  output logic                          byte_stored,
  output logic                          queue_empty,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  import uart_pkg::*;

  // Configuration.
  logic rx_enable;

  // Transmitter state.
  logic [FRAME_W-1:0]     tx_frame, tx_frame_next;
  logic [BITS_LEFT_W-1:0] tx_bits_left, tx_bits_left_next;
  logic                   tx_active, tx_active_next;
  logic                   tx_level, tx_level_next;

  // Receiver state.
  logic                 rx_armed, rx_armed_next;
  logic                 rx_awaiting_stop, rx_awaiting_stop_next;
  logic [BYTE_W-1:0]    rx_shift, rx_shift_next;
  logic [BIT_CNT_W-1:0] rx_bit_count, rx_bit_count_next;

  // Queue pointers.
  logic [PTR_W-1:0] write_pos, write_pos_next;
  logic [PTR_W-1:0] read_pos, read_pos_next;

  // Result flags for the next result register load.
  logic accepted_next, read_valid_next, byte_stored_next;

  logic              take;
  logic              push, pop;
  logic [BYTE_W-1:0] q_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;

  always_comb begin
    tx_frame_next         = tx_frame;
    tx_bits_left_next     = tx_bits_left;
    tx_active_next        = tx_active;
    tx_level_next         = tx_level;
    rx_armed_next         = rx_armed;
    rx_awaiting_stop_next = rx_awaiting_stop;
    rx_shift_next         = rx_shift;
    rx_bit_count_next     = rx_bit_count;
    write_pos_next        = write_pos;
    read_pos_next         = read_pos;
    accepted_next         = 1'b0;
    read_valid_next       = 1'b0;
    byte_stored_next      = 1'b0;
    push                  = 1'b0;
    pop                   = 1'b0;

    case (action)
      ACT_TICK: begin
        // Shift one frame bit onto the line; the frame ends when the count hits zero.
        if (tx_active) begin
          tx_level_next     = tx_frame[0];
          tx_frame_next     = tx_frame >> 1;
          tx_bits_left_next = tx_bits_left - 1'b1;
          if (tx_bits_left_next == '0) begin
            tx_active_next = 1'b0;
          end
        end
        // The receiver only advances while enabled; a disabled receiver keeps its place.
        if (rx_enable) begin
          if (rx_awaiting_stop) begin
            push                  = 1'b1;
            rx_shift_next         = '0;
            write_pos_next        = next_pos(write_pos);
            rx_armed_next         = 1'b0;
            rx_awaiting_stop_next = 1'b0;
            byte_stored_next      = 1'b1;
          end else if (rx_armed) begin
            if (rx_level) begin
              rx_shift_next[rx_bit_count] = 1'b1;
            end
            if (rx_bit_count == LAST_DATA_BIT) begin
              rx_awaiting_stop_next = 1'b1;
              rx_bit_count_next     = '0;
            end else begin
              rx_bit_count_next = rx_bit_count + 1'b1;
            end
          end
        end
      end
      ACT_EDGE: begin
        if (rx_enable && !rx_armed) begin
          rx_armed_next = 1'b1;
        end
      end
      ACT_SEND: begin
        // A send while a frame is in flight is rejected.
        if (!tx_active) begin
          tx_bits_left_next = FRAME_BITS;
          tx_frame_next     = STOP_MARK | {1'b0, tx_byte, 1'b0};
          tx_active_next    = 1'b1;
          accepted_next     = 1'b1;
        end
      end
      ACT_READ: begin
        if (read_pos != write_pos) begin
          pop             = 1'b1;
          read_pos_next   = next_pos(read_pos);
          read_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Receive queue storage; the read data register doubles as the result's byte.
  uart_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (take && push),
    .waddr (write_pos),
    .wdata (rx_shift),
    .re    (take && pop),
    .raddr (read_pos),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable        <= 1'b1;
      tx_frame         <= '0;
      tx_bits_left     <= '0;
      tx_active        <= 1'b0;
      tx_level         <= 1'b1;
      rx_armed         <= 1'b0;
      rx_awaiting_stop <= 1'b0;
      rx_shift         <= '0;
      rx_bit_count     <= '0;
      write_pos        <= '0;
      read_pos         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rx_enable <= cfg_data;
      end
      if (take) begin
        tx_frame         <= tx_frame_next;
        tx_bits_left     <= tx_bits_left_next;
        tx_active        <= tx_active_next;
        tx_level         <= tx_level_next;
        rx_armed         <= rx_armed_next;
        rx_awaiting_stop <= rx_awaiting_stop_next;
        rx_shift         <= rx_shift_next;
        rx_bit_count     <= rx_bit_count_next;
        write_pos        <= write_pos_next;
        read_pos         <= read_pos_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result flags load with each accepted request.
  always_ff @(posedge clk) begin
    if (take) begin
      accepted    <= accepted_next;
      read_valid  <= read_valid_next;
      byte_stored <= byte_stored_next;
    end
  end

  // State only moves on accepted requests, so the live registers already show
  // the state after the request held in the result register.
  assign tx_line     = tx_level;
  assign tx_busy     = tx_active;
  assign queue_empty = (write_pos == read_pos);
  assign read_byte   = read_valid ? q_rdata : '0;

endmodule

// File: rtl/core/uart_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one read port with registered data.
// Self-contained; no package dependency.
module uart_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
